// ----- rtl/psic_pkg.sv -----
// Shared types, constants and codes of the pointer shadow integrity checker.
`default_nettype none
package psic_pkg;

  localparam int TOP_INDEX_BITS_DEF  = 10;
  localparam int SLOT_INDEX_BITS_DEF = 10;
  localparam int POOL_PAGES_DEF      = 16;

  localparam int ADDR_W   = 23;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 3;
  // Log2 of bytes per protected slot: the low address bits below this are ignored.
  localparam int SLOT_SHIFT = 3;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  stored_copy;
  } out_res_t;

  typedef enum logic {
    RES_LOOK = 1'b0,
    RES_CMP  = 1'b1
  } res_sel_t;

  typedef struct packed {
    logic     clr;
    logic     capture;
    logic     pool_rd;
    logic     commit;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic top_hit;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/psic_ctrl.sv -----
// Controller state machine: clearing pass, request acceptance, lookup and compare sequencing.
`default_nettype none
module psic_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  psic_pkg::sts_t sts,
  output psic_pkg::cmd_t cmd
);
  import psic_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_LOOK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.op == OP_CHECK && sts.top_hit) begin
          cmd.pool_rd = 1'b1;
          state_nxt   = S_READ;
        end else if (out_free) begin
          // Hold the lookup until the result register can take the request's result.
          cmd.commit   = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_sel  = RES_CMP;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/psic_datapath.sv -----
// Datapath: top table and page pool memories, page allocator, clear counter and result register.
`default_nettype none
module psic_datapath #(
  parameter int TOP_INDEX_BITS  = psic_pkg::TOP_INDEX_BITS_DEF,
  parameter int SLOT_INDEX_BITS = psic_pkg::SLOT_INDEX_BITS_DEF,
  parameter int POOL_PAGES      = psic_pkg::POOL_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psic_pkg::in_req_t in_req,
  input  psic_pkg::cmd_t    cmd,
  output psic_pkg::sts_t    sts,
  output psic_pkg::out_res_t out_res
);
  import psic_pkg::*;

  localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int NW = $clog2(POOL_PAGES + 1);
  localparam int PA = PW + SLOT_INDEX_BITS;
  localparam int CW = (TOP_INDEX_BITS > PA) ? TOP_INDEX_BITS : PA;
  localparam int TOP_DEPTH = 1 << TOP_INDEX_BITS;
  localparam longint unsigned POOL_WORDS = 64'(POOL_PAGES) << SLOT_INDEX_BITS;

  logic [PW:0]    top_mem  [TOP_DEPTH];
  logic [VALUE_W-1:0] pool_mem [POOL_WORDS];

  logic                       op_r;
  logic [TOP_INDEX_BITS-1:0]  top_idx_r;
  logic [SLOT_INDEX_BITS-1:0] slot_r;
  logic [VALUE_W-1:0]         value_r;
  logic [PW:0]                top_q_r;
  logic [VALUE_W-1:0]         pool_q_r;
  logic [NW-1:0]              nfp_r;
  logic [CW-1:0]              clr_cnt_r;
  out_res_t                   out_res_r;
  out_res_t                   res_nxt;

  logic [ADDR_W+TOP_INDEX_BITS-1:0]  top_ext;
  logic [ADDR_W+SLOT_INDEX_BITS-1:0] slot_ext;
  logic [TOP_INDEX_BITS-1:0]         top_idx_in;
  logic [SLOT_INDEX_BITS-1:0]        slot_in;

  logic          top_hit, full, store_ok, alloc;
  logic [PW-1:0] top_page, new_page, store_page;
  logic          clr_top, clr_pool;

  logic                      top_we;
  logic [TOP_INDEX_BITS-1:0] top_wa;
  logic [PW:0]               top_wd;
  logic                      pool_we;
  logic [PA-1:0]             pool_wa;
  logic [VALUE_W-1:0]        pool_wd;

  // Split the address; bits beyond the input width read as zero.
  assign top_ext    = {{TOP_INDEX_BITS{1'b0}}, in_req.address} >> (SLOT_INDEX_BITS + SLOT_SHIFT);
  assign slot_ext   = {{SLOT_INDEX_BITS{1'b0}}, in_req.address} >> SLOT_SHIFT;
  assign top_idx_in = top_ext[TOP_INDEX_BITS-1:0];
  assign slot_in    = slot_ext[SLOT_INDEX_BITS-1:0];

  assign top_hit    = top_q_r[PW];
  assign top_page   = top_q_r[PW-1:0];
  assign full       = (nfp_r == NW'(POOL_PAGES));
  assign new_page   = nfp_r[PW-1:0];
  assign store_page = top_hit ? top_page : new_page;
  assign store_ok   = cmd.commit && (op_r == OP_STORE) && (top_hit || !full);
  assign alloc      = store_ok && !top_hit;

  assign clr_top  = cmd.clr && ({1'b0, clr_cnt_r} < (CW+1)'(TOP_DEPTH));
  assign clr_pool = cmd.clr && ({1'b0, clr_cnt_r} < (CW+1)'(POOL_WORDS));

  always_comb begin
    if (cmd.clr) begin
      top_we  = clr_top;
      top_wa  = clr_cnt_r[TOP_INDEX_BITS-1:0];
      top_wd  = '0;
      pool_we = clr_pool;
      pool_wa = clr_cnt_r[PA-1:0];
      pool_wd = '0;
    end else begin
      top_we  = alloc;
      top_wa  = top_idx_r;
      top_wd  = {1'b1, new_page};
      pool_we = store_ok;
      pool_wa = {store_page, slot_r};
      pool_wd = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (top_we) top_mem[top_wa] <= top_wd;
    if (cmd.capture) top_q_r <= top_mem[top_idx_in];
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    if (cmd.pool_rd) pool_q_r <= pool_mem[{top_page, slot_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_req.operation;
      top_idx_r <= top_idx_in;
      slot_r    <= slot_in;
      value_r   <= in_req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfp_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (alloc) nfp_r <= nfp_r + NW'(1);
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  always_comb begin
    res_nxt.stored_copy = '0;
    case (cmd.res_sel)
      RES_CMP: begin
        res_nxt.stored_copy = pool_q_r;
        res_nxt.status      = (pool_q_r == value_r) ? ST_MATCH : ST_MISMATCH;
      end
      default: begin
        if (op_r == OP_CHECK) res_nxt.status = ST_NO_PAGE;
        else if (top_hit || !full) res_nxt.status = ST_STORED;
        else res_nxt.status = ST_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_res_r <= res_nxt;
  end

  assign out_res      = out_res_r;
  assign sts.op       = op_r;
  assign sts.top_hit  = top_hit;
  assign sts.clr_last = (clr_cnt_r == '1);

endmodule
`default_nettype wire

// ----- rtl/pointer_shadow_integrity_checker_unit.sv -----
// Top level: a store reads the top table and then commits; a check reads the top table,
// then on a hit reads the page pool and compares. One request is in work at a time, so a
// new request is taken only once the last one has loaded its result. The result register
// lets the next request be taken while a result waits. After reset a clearing pass zeroes
// the top table and page pool; requests are stalled until it ends.
`default_nettype none
module pointer_shadow_integrity_checker_unit #(
  parameter int TOP_INDEX_BITS  = psic_pkg::TOP_INDEX_BITS_DEF,
  parameter int SLOT_INDEX_BITS = psic_pkg::SLOT_INDEX_BITS_DEF,
  parameter int POOL_PAGES      = psic_pkg::POOL_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psic_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output psic_pkg::out_res_t out_res
);
  import psic_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psic_datapath #(
    .TOP_INDEX_BITS  (TOP_INDEX_BITS),
    .SLOT_INDEX_BITS (SLOT_INDEX_BITS),
    .POOL_PAGES      (POOL_PAGES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

  // Only one request in work: the cycle after acceptance the input side stalls.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in work");

  // Stall during the clearing pass that follows reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register loaded while a result is stalled");

  // A pool read is always followed by the compare step, never a new request.
  a_read_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pool_rd |=> (in_stall && !cmd.capture))
    else $error("pool read not followed by compare");

endmodule
`default_nettype wire
